// ===== design/bds_pkg.sv =====
// Package: sizes, register codes, payload types and size clamping for the 2x2 downsampler.
package bds_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int SIZE_W  = 13;
  localparam int PIX_W   = 8;
  localparam int SUM_W   = PIX_W + 1;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int LINE_DW    = 3 * SUM_W;

  localparam int SIZE_MAX_EVEN = (1 << SIZE_W) - 2;
  localparam int WIDTH_CAP  = ((MAX_WIDTH & ~1) > SIZE_MAX_EVEN) ? SIZE_MAX_EVEN
                                                                  : (MAX_WIDTH & ~1);
  localparam int HEIGHT_CAP = ((MAX_HEIGHT & ~1) > SIZE_MAX_EVEN) ? SIZE_MAX_EVEN
                                                                   : (MAX_HEIGHT & ~1);

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam int QDEPTH   = 3;
  localparam int Q_PTR_W  = $clog2(QDEPTH);
  localparam int Q_CNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } chan_sum_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             last;
  } result_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] value,
                                                 input logic [SIZE_W-1:0] cap);
    logic [SIZE_W-1:0] v;
    v = value & ~SIZE_W'(1);
    if (v == '0) begin
      v = SIZE_W'(2);
    end
    if (v > cap) begin
      v = cap;
    end
    return v;
  endfunction

endpackage

// ===== design/bds_if.sv =====
// Interfaces: pixel input, result output and configuration write channels.
interface bds_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [bds_pkg::PIX_W-1:0]  pixel_red;
  logic [bds_pkg::PIX_W-1:0]  pixel_green;
  logic [bds_pkg::PIX_W-1:0]  pixel_blue;

  modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                  input ready);
  modport sink (input valid, input pixel_red, input pixel_green, input pixel_blue,
                output ready);
endinterface

interface bds_result_if;
  logic                       valid;
  logic                       ready;
  logic [bds_pkg::PIX_W-1:0]  out_red;
  logic [bds_pkg::PIX_W-1:0]  out_green;
  logic [bds_pkg::PIX_W-1:0]  out_blue;
  logic                       frame_last;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output frame_last, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input frame_last, output ready);
endinterface

interface bds_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bds_pkg::CFG_IDX_W-1:0]  index;
  logic [bds_pkg::SIZE_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/bds_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/box_downsample_2x2_rgb.sv =====
// Top level: 2x2 box-filter downsampler for a raster-order RGB pixel stream.
//
// Pixels enter on pixel_in in raster order; each 2x2 block of the input
// frame yields one averaged pixel (per-channel sum shifted right by two) on
// result_out, with frame_last set on the final block of the frame. Frame
// width and height are written on cfg (index 0 width, index 1 height); the
// low bit is ignored, zero acts as 2, oversize clamps to 4096 (line store
// limit for width, MAX_HEIGHT for height). Any size write restarts the frame
// at the top-left pixel. Throughput: one pixel per clock while pixel_in.ready
// is high. A result passes the line store read and the final add into the
// output queue, both registered, before it appears on result_out.
// Even rows store horizontal pair sums in a one-port-write, one-port-read
// line memory; odd rows read them back. A three-entry output queue lets
// pixel_in keep flowing while result_out is stalled; pixel_in.ready drops
// only when the queue plus the pending read could not take another result.
// Reset restores 640x480, clears the counters and empties the queue; the
// line memory needs no clearing since each entry is written before it is read.
module box_downsample_2x2_rgb (
  input  logic            clk,
  input  logic            rst,
  bds_pixel_if.sink       pixel_in,
  bds_result_if.source    result_out,
  bds_cfg_if.sink         cfg
);

  logic [bds_pkg::COL_W-1:0]   col;
  logic [bds_pkg::ROW_W-1:0]   row;
  logic [bds_pkg::COL_W-1:0]   wid_last;
  logic [bds_pkg::ROW_W-1:0]   hgt_last;
  logic [bds_pkg::SIZE_W-1:0]  size_eff;
  logic                        cfg_acc;
  logic                        cfg_hit;
  logic                        pix_acc;
  logic                        col_end;
  logic                        row_end;

  bds_pkg::chan_sum_t          pair;
  bds_pkg::chan_sum_t          pair_next;
  bds_pkg::chan_sum_t          s1_pair;
  bds_pkg::chan_sum_t          above;
  logic                        s1_valid;
  logic                        s1_last;

  logic                        ram_we;
  logic                        ram_re;
  logic [bds_pkg::LINE_AW-1:0] ram_addr;
  logic [bds_pkg::LINE_DW-1:0] ram_rdata;

  logic [bds_pkg::SUM_W:0]     sum_red;
  logic [bds_pkg::SUM_W:0]     sum_green;
  logic [bds_pkg::SUM_W:0]     sum_blue;
  bds_pkg::result_t            s1_result;

  bds_pkg::result_t            q_data [bds_pkg::QDEPTH];
  logic [bds_pkg::Q_PTR_W-1:0] q_head;
  logic [bds_pkg::Q_PTR_W-1:0] q_tail;
  logic [bds_pkg::Q_CNT_W-1:0] q_count;
  logic [bds_pkg::Q_CNT_W-1:0] q_count_next;
  logic [bds_pkg::Q_CNT_W:0]   q_load;
  logic                        q_pop;
  bds_pkg::result_t            q_head_data;

  // Configuration
  assign cfg.ready = 1'b1;
  assign cfg_acc   = cfg.valid & cfg.ready;
  assign cfg_hit   = cfg_acc && (cfg.index == bds_pkg::REG_FRAME_WIDTH ||
                                 cfg.index == bds_pkg::REG_FRAME_HEIGHT);

  always_comb begin
    if (cfg.index == bds_pkg::REG_FRAME_WIDTH) begin
      size_eff = bds_pkg::eff_size(cfg.data, bds_pkg::SIZE_W'(bds_pkg::WIDTH_CAP));
    end else begin
      size_eff = bds_pkg::eff_size(cfg.data, bds_pkg::SIZE_W'(bds_pkg::HEIGHT_CAP));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wid_last <= bds_pkg::COL_W'(bds_pkg::RESET_WIDTH - 1);
      hgt_last <= bds_pkg::ROW_W'(bds_pkg::RESET_HEIGHT - 1);
    end else if (cfg_acc) begin
      case (cfg.index)
        bds_pkg::REG_FRAME_WIDTH: begin
          wid_last <= bds_pkg::COL_W'(size_eff - bds_pkg::SIZE_W'(1));
        end
        bds_pkg::REG_FRAME_HEIGHT: begin
          hgt_last <= bds_pkg::ROW_W'(size_eff - bds_pkg::SIZE_W'(1));
        end
        default: begin
        end
      endcase
    end
  end

  // Input side: counters, pair sums, line store access
  assign q_load         = {1'b0, q_count} + {{bds_pkg::Q_CNT_W{1'b0}}, s1_valid};
  assign pixel_in.ready = q_load < (bds_pkg::Q_CNT_W + 1)'(bds_pkg::QDEPTH);
  assign pix_acc        = pixel_in.valid & pixel_in.ready;
  assign col_end        = col == wid_last;
  assign row_end        = row == hgt_last;

  always_comb begin
    pair_next.red   = pair.red   + {1'b0, pixel_in.pixel_red};
    pair_next.green = pair.green + {1'b0, pixel_in.pixel_green};
    pair_next.blue  = pair.blue  + {1'b0, pixel_in.pixel_blue};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg_hit) begin
      col <= '0;
      row <= '0;
    end else if (pix_acc) begin
      if (col_end) begin
        col <= '0;
        row <= row_end ? '0 : row + bds_pkg::ROW_W'(1);
      end else begin
        col <= col + bds_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc && !col[0]) begin
      pair.red   <= {1'b0, pixel_in.pixel_red};
      pair.green <= {1'b0, pixel_in.pixel_green};
      pair.blue  <= {1'b0, pixel_in.pixel_blue};
    end
  end

  assign ram_we   = pix_acc & col[0] & ~row[0];
  assign ram_re   = pix_acc & col[0] & row[0];
  assign ram_addr = col[bds_pkg::COL_W-1:1];

  bds_ram #(
    .WIDTH (bds_pkg::LINE_DW),
    .DEPTH (bds_pkg::LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (pair_next),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // Stage 1: line store data returns, finish the block sum
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      s1_pair <= pair_next;
      s1_last <= col_end & row_end;
    end
  end

  assign above     = bds_pkg::chan_sum_t'(ram_rdata);
  assign sum_red   = {1'b0, above.red}   + {1'b0, s1_pair.red};
  assign sum_green = {1'b0, above.green} + {1'b0, s1_pair.green};
  assign sum_blue  = {1'b0, above.blue}  + {1'b0, s1_pair.blue};

  always_comb begin
    s1_result.red   = sum_red[bds_pkg::SUM_W:2];
    s1_result.green = sum_green[bds_pkg::SUM_W:2];
    s1_result.blue  = sum_blue[bds_pkg::SUM_W:2];
    s1_result.last  = s1_last;
  end

  // Output queue
  assign q_pop       = result_out.valid & result_out.ready;
  assign q_head_data = q_data[q_head];

  always_comb begin
    q_count_next = q_count;
    if (s1_valid && !q_pop) begin
      q_count_next = q_count + bds_pkg::Q_CNT_W'(1);
    end else if (!s1_valid && q_pop) begin
      q_count_next = q_count - bds_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_head  <= '0;
      q_tail  <= '0;
      q_count <= '0;
    end else begin
      q_count <= q_count_next;
      if (s1_valid) begin
        q_tail <= (q_tail == bds_pkg::Q_PTR_W'(bds_pkg::QDEPTH - 1)) ?
                  '0 : q_tail + bds_pkg::Q_PTR_W'(1);
      end
      if (q_pop) begin
        q_head <= (q_head == bds_pkg::Q_PTR_W'(bds_pkg::QDEPTH - 1)) ?
                  '0 : q_head + bds_pkg::Q_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      q_data[q_tail] <= s1_result;
    end
  end

  assign result_out.valid      = q_count != '0;
  assign result_out.out_red    = q_head_data.red;
  assign result_out.out_green  = q_head_data.green;
  assign result_out.out_blue   = q_head_data.blue;
  assign result_out.frame_last = q_head_data.last;

  // Checks
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_load <= (bds_pkg::Q_CNT_W + 1)'(bds_pkg::QDEPTH))
    else $error("output queue overflow");

  a_read_origin: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $past(pix_acc) && $past(col[0]) && $past(row[0]))
    else $error("block sum without an odd-row odd-column pixel");

  a_ram_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("line store read and write in one cycle");

  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    pix_acc && !cfg_hit |=> col <= wid_last)
    else $error("column counter beyond frame width");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    ram_re && col_end && row_end |=> col == '0 && row == '0)
    else $error("frame end did not wrap counters");

endmodule

// ===== test/bds_block_checker.sv =====
// Block checker: predicts 2x2 block averages from accepted pixels and compares result transactions.
module bds_block_checker (
  input  logic                       clk,
  input  logic                       rst,
  bds_pixel_if                       pixel_ch,
  bds_result_if                      result_ch,
  bds_cfg_if                         cfg_ch,
  output int                         mismatches,
  output int                         blocks_due,
  output logic [bds_pkg::SIZE_W-1:0] cols,
  output logic [bds_pkg::SIZE_W-1:0] rows
);

  logic [bds_pkg::SIZE_W-1:0] width_reg;
  logic [bds_pkg::SIZE_W-1:0] height_reg;
  logic [bds_pkg::SIZE_W-1:0] col_pos;
  logic [bds_pkg::SIZE_W-1:0] row_pos;
  bds_pkg::chan_sum_t         pair_acc;
  bds_pkg::chan_sum_t         line_mem [bds_pkg::LINE_DEPTH];
  bds_pkg::result_t           expected_blocks [$];
  bds_pkg::result_t           seen_blk;
  bds_pkg::result_t           want_blk;

  function automatic logic [bds_pkg::SIZE_W-1:0] usable_size(
      input logic [bds_pkg::SIZE_W-1:0] raw,
      input logic [bds_pkg::SIZE_W-1:0] cap);
    logic [bds_pkg::SIZE_W-1:0] even;
    even = {raw[bds_pkg::SIZE_W-1:1], 1'b0};
    if (even == '0) begin
      even = bds_pkg::SIZE_W'(2);
    end
    if (even > cap) begin
      even = cap;
    end
    return even;
  endfunction

  assign cols = usable_size(width_reg, bds_pkg::SIZE_W'(bds_pkg::WIDTH_CAP));
  assign rows = usable_size(height_reg, bds_pkg::SIZE_W'(bds_pkg::HEIGHT_CAP));

  task automatic fold_pixel(input logic [bds_pkg::PIX_W-1:0] r,
                            input logic [bds_pkg::PIX_W-1:0] g,
                            input logic [bds_pkg::PIX_W-1:0] b);
    logic [bds_pkg::SIZE_W-1:0]  c;
    logic [bds_pkg::SIZE_W-1:0]  rw;
    logic [bds_pkg::LINE_AW-1:0] slot;
    bds_pkg::chan_sum_t          above;
    bds_pkg::result_t            blk;
    c  = (col_pos >= cols) ? '0 : col_pos;
    rw = (row_pos >= rows) ? '0 : row_pos;
    if (!c[0]) begin
      pair_acc.red   = bds_pkg::SUM_W'(r);
      pair_acc.green = bds_pkg::SUM_W'(g);
      pair_acc.blue  = bds_pkg::SUM_W'(b);
    end else begin
      slot = c[bds_pkg::LINE_AW:1];
      pair_acc.red   = pair_acc.red + bds_pkg::SUM_W'(r);
      pair_acc.green = pair_acc.green + bds_pkg::SUM_W'(g);
      pair_acc.blue  = pair_acc.blue + bds_pkg::SUM_W'(b);
      if (!rw[0]) begin
        line_mem[slot] = pair_acc;
      end else begin
        above     = line_mem[slot];
        blk.red   = bds_pkg::PIX_W'(({1'b0, above.red} + {1'b0, pair_acc.red}) >> 2);
        blk.green = bds_pkg::PIX_W'(({1'b0, above.green} + {1'b0, pair_acc.green}) >> 2);
        blk.blue  = bds_pkg::PIX_W'(({1'b0, above.blue} + {1'b0, pair_acc.blue}) >> 2);
        blk.last  = (c == cols - bds_pkg::SIZE_W'(1)) && (rw == rows - bds_pkg::SIZE_W'(1));
        expected_blocks.push_back(blk);
      end
    end
    c = c + bds_pkg::SIZE_W'(1);
    if (c >= cols) begin
      c  = '0;
      rw = rw + bds_pkg::SIZE_W'(1);
      if (rw >= rows) begin
        rw = '0;
      end
    end
    col_pos = c;
    row_pos = rw;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = bds_pkg::SIZE_W'(bds_pkg::RESET_WIDTH);
      height_reg = bds_pkg::SIZE_W'(bds_pkg::RESET_HEIGHT);
      col_pos    = '0;
      row_pos    = '0;
      pair_acc   = '0;
      expected_blocks.delete();
      mismatches <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        seen_blk.red   = result_ch.out_red;
        seen_blk.green = result_ch.out_green;
        seen_blk.blue  = result_ch.out_blue;
        seen_blk.last  = result_ch.frame_last;
        if (expected_blocks.size() == 0) begin
          $display("%0t: result with no block pending: r=%0d g=%0d b=%0d last=%0b", $time,
                   seen_blk.red, seen_blk.green, seen_blk.blue, seen_blk.last);
          mismatches <= mismatches + 1;
        end else begin
          want_blk = expected_blocks.pop_front();
          if (seen_blk !== want_blk) begin
            $display("%0t: block mismatch: expected r=%0d g=%0d b=%0d last=%0b,", $time,
                     want_blk.red, want_blk.green, want_blk.blue, want_blk.last,
                     " actual r=%0d g=%0d b=%0d last=%0b",
                     seen_blk.red, seen_blk.green, seen_blk.blue, seen_blk.last);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (pixel_ch.valid && pixel_ch.ready) begin
        fold_pixel(pixel_ch.pixel_red, pixel_ch.pixel_green, pixel_ch.pixel_blue);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          bds_pkg::REG_FRAME_WIDTH: begin
            width_reg = cfg_ch.data;
            col_pos   = '0;
            row_pos   = '0;
          end
          bds_pkg::REG_FRAME_HEIGHT: begin
            height_reg = cfg_ch.data;
            col_pos    = '0;
            row_pos    = '0;
          end
          default: begin
          end
        endcase
      end
    end
    blocks_due <= expected_blocks.size();
  end

endmodule

// ===== test/tb_box_downsample_2x2_rgb.sv =====
// Testbench top: drives pixel, result and size-register transactions and reports the verdict.
module tb_box_downsample_2x2_rgb;

  localparam logic [bds_pkg::CFG_IDX_W-1:0] REG_UNUSED = bds_pkg::CFG_IDX_W'(15);
  localparam int ITEMS = 1000;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  int                         mismatches;
  int                         blocks_due;
  logic [bds_pkg::SIZE_W-1:0] cols;
  logic [bds_pkg::SIZE_W-1:0] rows;
  bit                         src_steady;
  bit                         snk_steady;
  int                         fed;

  bds_pixel_if  pix_ch ();
  bds_result_if res_ch ();
  bds_cfg_if    cfg_ch ();

  box_downsample_2x2_rgb dut (
    .clk        (clk),
    .rst        (rst),
    .pixel_in   (pix_ch),
    .result_out (res_ch),
    .cfg        (cfg_ch)
  );

  bds_block_checker blocks (
    .clk        (clk),
    .rst        (rst),
    .pixel_ch   (pix_ch),
    .result_ch  (res_ch),
    .cfg_ch     (cfg_ch),
    .mismatches (mismatches),
    .blocks_due (blocks_due),
    .cols       (cols),
    .rows       (rows)
  );

  always #2 clk = ~clk;

  function automatic logic [bds_pkg::PIX_W-1:0] channel_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return bds_pkg::PIX_W'($urandom());
    endcase
  endfunction

  task automatic push_pixel(input logic [bds_pkg::PIX_W-1:0] r,
                            input logic [bds_pkg::PIX_W-1:0] g,
                            input logic [bds_pkg::PIX_W-1:0] b);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel_red   <= r;
    pix_ch.pixel_green <= g;
    pix_ch.pixel_blue  <= b;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    fed++;
  endtask

  task automatic push_random(input int n);
    repeat (n) push_pixel(channel_value(), channel_value(), channel_value());
  endtask

  // drain pending blocks, then cover pixels still in the pipeline
  task automatic settle();
    @(negedge clk);
    pix_ch.valid <= 1'b0;
    while (blocks_due != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bds_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bds_pkg::SIZE_W-1:0] value);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int stall;
    res_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      stall = snk_steady ? 0 : $urandom_range(0, 14);
      @(negedge clk);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
    end
  end

  initial begin
    forever begin
      repeat ($urandom_range(100, 800)) @(negedge clk);
      src_steady <= ($urandom_range(0, 3) == 0);
      snk_steady <= ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int n;
    int area;
    int pick;
    pix_ch.valid       = 1'b0;
    pix_ch.pixel_red   = '0;
    pix_ch.pixel_green = '0;
    pix_ch.pixel_blue  = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = bds_pkg::REG_FRAME_WIDTH;
    cfg_ch.data        = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // first blocks of the second row at the reset frame size
    push_random(bds_pkg::RESET_WIDTH + 4);

    write_reg(bds_pkg::REG_FRAME_WIDTH, bds_pkg::SIZE_W'(2));
    write_reg(bds_pkg::REG_FRAME_HEIGHT, bds_pkg::SIZE_W'(2));
    repeat (4) push_pixel('1, '1, '1);
    repeat (4) push_pixel('0, '0, '0);

    // zero width and odd height both act as 2
    write_reg(bds_pkg::REG_FRAME_WIDTH, bds_pkg::SIZE_W'(0));
    write_reg(bds_pkg::REG_FRAME_HEIGHT, bds_pkg::SIZE_W'(3));
    push_pixel(8'd255, 8'd0, 8'd255);
    push_pixel(8'd0, 8'd255, 8'd0);
    push_pixel(8'd1, 8'd2, 8'd3);
    push_pixel(8'd254, 8'd253, 8'd252);

    write_reg(REG_UNUSED, '1);
    push_random(4);

    // restart mid-frame on a size write
    write_reg(bds_pkg::REG_FRAME_WIDTH, bds_pkg::SIZE_W'(4));
    write_reg(bds_pkg::REG_FRAME_HEIGHT, bds_pkg::SIZE_W'(4));
    push_random(6);
    write_reg(bds_pkg::REG_FRAME_HEIGHT, bds_pkg::SIZE_W'(5));
    push_random(6);

    // oversize widths and heights
    write_reg(bds_pkg::REG_FRAME_WIDTH, '1);
    write_reg(bds_pkg::REG_FRAME_HEIGHT, bds_pkg::SIZE_W'(2));
    push_random(8);
    write_reg(bds_pkg::REG_FRAME_WIDTH, bds_pkg::SIZE_W'(3));
    write_reg(bds_pkg::REG_FRAME_HEIGHT, '1);
    push_random(int'(cols) * 8);

    while (fed < ITEMS) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        write_reg(bds_pkg::CFG_IDX_W'($urandom_range(2, 15)), bds_pkg::SIZE_W'($urandom()));
      end
      if (pick != 1) begin
        write_reg(bds_pkg::REG_FRAME_WIDTH,
                  ($urandom_range(0, 7) == 0) ? bds_pkg::SIZE_W'($urandom())
                                              : bds_pkg::SIZE_W'($urandom_range(0, 33)));
      end
      if (pick != 2) begin
        write_reg(bds_pkg::REG_FRAME_HEIGHT,
                  ($urandom_range(0, 7) == 0) ? bds_pkg::SIZE_W'($urandom())
                                              : bds_pkg::SIZE_W'($urandom_range(0, 17)));
      end
      area = int'(cols) * int'(rows);
      if (area <= 1200) begin
        n = area * $urandom_range(1, 2);
        if ($urandom_range(0, 1) == 1) begin
          n = n + $urandom_range(0, area - 1);
        end
      end else begin
        n = $urandom_range(1, 300);
      end
      if (n > ITEMS - fed) begin
        n = ITEMS - fed;
      end
      push_random(n);
    end

    @(negedge clk);
    pix_ch.valid <= 1'b0;
    n = 0;
    while (blocks_due != 0 && n < 20000) begin
      @(negedge clk);
      n++;
    end
    repeat (10) @(negedge clk);
    if (mismatches == 0 && blocks_due == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
